// File: rtl/core/rls_pkg.sv
// ----------------------------------------------------------------------------
// rls_pkg
// shared types, codes and character constants of the regex literal scanner
// ----------------------------------------------------------------------------
package rls_pkg;

   // scan states
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_BODY      = 3'd1;
   localparam logic [2:0] ST_CLASS     = 3'd2;
   localparam logic [2:0] ST_ESC_BODY  = 3'd3;
   localparam logic [2:0] ST_ESC_CLASS = 3'd4;
   localparam logic [2:0] ST_FLAGS     = 3'd5;

   // result kinds
   localparam logic [1:0] KIND_PATTERN  = 2'd0;
   localparam logic [1:0] KIND_COMPLETE = 2'd1;
   localparam logic [1:0] KIND_UNTERM   = 2'd2;
   localparam logic [1:0] KIND_BAD_FLAG = 2'd3;

   // flag bits
   localparam logic [2:0] FLAG_G = 3'b001;
   localparam logic [2:0] FLAG_I = 3'b010;
   localparam logic [2:0] FLAG_M = 3'b100;

   // characters
   localparam logic [7:0] CH_G      = 8'h67;
   localparam logic [7:0] CH_I      = 8'h69;
   localparam logic [7:0] CH_M      = 8'h6d;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_LBRACK = 8'h5b;
   localparam logic [7:0] CH_RBRACK = 8'h5d;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_SEMI   = 8'h3b;
   localparam logic [7:0] CH_RBRACE = 8'h7d;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_COMMA  = 8'h2c;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_DOT    = 8'h2e;

   // most results one byte can cause, and result queue depth
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int NUM_W       = $clog2(MAX_RESULTS + 1);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [2:0] flags;
      logic       byte_consumed;
      logic       last_of_run;
   } result_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      result_type [MAX_RESULTS-1:0] res;
   } step_type;

   function automatic logic is_line_break(input logic [7:0] c);
      return (c == CH_LF) || (c == CH_CR);
   endfunction

   function automatic logic is_terminator(input logic [7:0] c);
      return (c == CH_SEMI) || (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
             (c == CH_LF) || (c == CH_COMMA) || (c == CH_RPAREN) ||
             (c == CH_RBRACK) || (c == CH_RBRACE) || (c == CH_DOT);
   endfunction

endpackage

// File: rtl/core/regex_literal_scanner.sv
// ----------------------------------------------------------------------------
// regex_literal_scanner
// scans the bytes after the opening slash of a regular-expression literal
// ----------------------------------------------------------------------------
// usage
//   req_ channel: one source byte per beat, with req_first marking the first
//   byte of a new literal and req_end_of_text marking the last source byte
//   rsp_ channel: one result per beat; a byte gives zero to three results,
//   the last of them carrying rsp_last_of_run
//   results are registered in the result queue before they are offered;
//   later ones of the same byte follow in order
//   throughput: one byte per cycle while each byte gives at most one result and
//   the receiver takes every beat; the single-beat response port sets the rate,
//   so a byte with several results holds the output for one beat per result
//   req_ready is high while the four-entry result queue holds at most one
//   result, so with the receiver stalled req_ready drops as soon as two
//   results wait
//   reset: the scan goes idle, flags clear and the queue empties; in idle,
//   bytes not marked first are taken and dropped
// ----------------------------------------------------------------------------
module regex_literal_scanner (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_first,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_flag_global,
   output logic       rsp_flag_ignore_case,
   output logic       rsp_flag_multiline,
   output logic       rsp_byte_consumed,
   output logic       rsp_last_of_run
);
   import rls_pkg::*;

   logic [2:0] state_ff, state_in;
   logic [2:0] flags_ff, flags_in;
   logic       accept;
   step_type   step;
   result_type res;

   assign accept = req_valid && req_ready;

   // scan logic for the byte on the request port
   rls_step u_step (
      .state       (state_ff),
      .flags       (flags_ff),
      .in_byte     (req_in_byte),
      .first       (req_first),
      .end_of_text (req_end_of_text),
      .state_next  (state_in),
      .flags_next  (flags_in),
      .step        (step)
   );

   // scan state only moves on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         flags_ff <= 3'b000;
      end else if (accept) begin
         state_ff <= state_in;
         flags_ff <= flags_in;
      end
   end

   // results wait here for the receiver
   rls_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .step      (step),
      .room      (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_res   (res)
   );

   assign rsp_kind             = res.kind;
   assign rsp_out_byte         = res.out_byte;
   assign rsp_flag_global      = res.flags[0];
   assign rsp_flag_ignore_case = res.flags[1];
   assign rsp_flag_multiline   = res.flags[2];
   assign rsp_byte_consumed    = res.byte_consumed;
   assign rsp_last_of_run      = res.last_of_run;

endmodule

// File: rtl/core/rls_step.sv
// ----------------------------------------------------------------------------
// rls_step
// next-state and result logic for one source byte
// ----------------------------------------------------------------------------
module rls_step (
   input  logic [2:0]        state,
   input  logic [2:0]        flags,
   input  logic [7:0]        in_byte,
   input  logic              first,
   input  logic              end_of_text,
   output logic [2:0]        state_next,
   output logic [2:0]        flags_next,
   output rls_pkg::step_type step
);
   import rls_pkg::*;

   logic [2:0] cur_state;
   logic [2:0] cur_flags;
   logic [2:0] bit_sel;
   logic       pre_bs;
   result_type r_pat;
   result_type r_unterm;
   result_type r_bad;
   result_type r_done;

   always_comb begin
      cur_state = first ? ST_BODY : state;
      cur_flags = first ? 3'b000 : flags;
      pre_bs    = (cur_state == ST_BODY) && (in_byte == CH_RBRACK);

      r_pat    = '{kind: KIND_PATTERN, out_byte: in_byte, flags: 3'b000,
                   byte_consumed: 1'b1, last_of_run: 1'b0};
      r_unterm = '{kind: KIND_UNTERM, out_byte: 8'h00, flags: 3'b000,
                   byte_consumed: 1'b1, last_of_run: 1'b0};
      r_bad    = '{kind: KIND_BAD_FLAG, out_byte: 8'h00, flags: 3'b000,
                   byte_consumed: 1'b1, last_of_run: 1'b0};
      r_done   = '{kind: KIND_COMPLETE, out_byte: 8'h00, flags: cur_flags,
                   byte_consumed: 1'b1, last_of_run: 1'b0};

      case (in_byte)
         CH_G:    bit_sel = FLAG_G;
         CH_I:    bit_sel = FLAG_I;
         CH_M:    bit_sel = FLAG_M;
         default: bit_sel = 3'b000;
      endcase

      state_next = cur_state;
      flags_next = cur_flags;
      step.num   = '0;
      step.res   = {MAX_RESULTS{r_unterm}};

      unique case (cur_state)
         ST_BODY, ST_CLASS, ST_ESC_BODY, ST_ESC_CLASS: begin
            if (is_line_break(in_byte)) begin
               step.res[0] = r_unterm;
               step.num    = NUM_W'(1);
               state_next  = ST_IDLE;
            end else if ((cur_state == ST_BODY) && (in_byte == CH_SLASH)) begin
               flags_next = 3'b000;
               if (end_of_text) begin
                  step.res[0]       = r_done;
                  step.res[0].flags = 3'b000;
                  step.num          = NUM_W'(1);
                  state_next        = ST_IDLE;
               end else begin
                  state_next = ST_FLAGS;
               end
            end else begin
               unique case (cur_state)
                  ST_BODY: begin
                     if (in_byte == CH_LBRACK) begin
                        state_next = ST_CLASS;
                     end else if (in_byte == CH_BSLASH) begin
                        state_next = ST_ESC_BODY;
                     end
                  end
                  ST_CLASS: begin
                     if (in_byte == CH_RBRACK) begin
                        state_next = ST_BODY;
                     end else if (in_byte == CH_BSLASH) begin
                        state_next = ST_ESC_CLASS;
                     end
                  end
                  ST_ESC_BODY:  state_next = ST_BODY;
                  default:      state_next = ST_CLASS;
               endcase
               // lone closing bracket gets a backslash in front
               if (pre_bs) begin
                  step.res[0]          = r_pat;
                  step.res[0].out_byte = CH_BSLASH;
                  step.res[1]          = r_pat;
               end else begin
                  step.res[0] = r_pat;
               end
               step.num = NUM_W'(1) + NUM_W'(pre_bs) + NUM_W'(end_of_text);
               if (end_of_text) begin
                  state_next = ST_IDLE;
               end
            end
         end
         ST_FLAGS: begin
            if (bit_sel != 3'b000) begin
               if ((cur_flags & bit_sel) != 3'b000) begin
                  step.res[0] = r_bad;
                  step.num    = NUM_W'(1);
                  state_next  = ST_IDLE;
               end else begin
                  flags_next = cur_flags | bit_sel;
                  if (end_of_text) begin
                     step.res[0]       = r_done;
                     step.res[0].flags = cur_flags | bit_sel;
                     step.num          = NUM_W'(1);
                     state_next        = ST_IDLE;
                  end
               end
            end else if (is_terminator(in_byte)) begin
               step.res[0]               = r_done;
               step.res[0].byte_consumed = 1'b0;
               step.num                  = NUM_W'(1);
               state_next                = ST_IDLE;
            end else begin
               step.res[0] = r_bad;
               step.num    = NUM_W'(1);
               state_next  = ST_IDLE;
            end
         end
         default: begin
            state_next = ST_IDLE;
         end
      endcase

      for (int i = 0; i < MAX_RESULTS; i++) begin
         step.res[i].last_of_run = (NUM_W'(i + 1) == step.num);
      end
   end

endmodule

// File: rtl/core/rls_queue.sv
// ----------------------------------------------------------------------------
// rls_queue
// result queue: takes up to three results a cycle, hands out one per beat
// ----------------------------------------------------------------------------
module rls_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  rls_pkg::step_type            step,
   output logic                         room,
   output logic                         out_valid,
   input  logic                         out_ready,
   output rls_pkg::result_type          out_res
);
   import rls_pkg::*;

   result_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [NUM_W-1:0] add;
   logic             pop;

   assign pop       = out_valid && out_ready;
   assign add       = push ? step.num : '0;
   assign out_valid = (count_ff != '0);
   assign out_res   = entry_ff[rd_ptr_ff];
   // room for a worst-case byte even with no beat taken
   assign room      = (count_ff <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(add);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(add) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (NUM_W'(i) < add) begin
            entry_ff[wr_ptr_ff + PTR_W'(i)] <= step.res[i];
         end
      end
   end

endmodule

// File: rtl/core/rls_checker.sv
// ----------------------------------------------------------------------------
// rls_checker
// port-level checks of the regex literal scanner
// ----------------------------------------------------------------------------
module rls_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_flag_global,
   input logic       rsp_flag_ignore_case,
   input logic       rsp_flag_multiline,
   input logic       rsp_byte_consumed,
   input logic       rsp_last_of_run
);
   import rls_pkg::*;

   // a result cannot appear without a byte taken before it
   a_no_result_from_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result offered straight after reset");

   // a held result stays valid and keeps its kind, byte and last-of-run mark until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_out_byte) && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   // only pattern results carry a byte, only completions carry flags
   a_payload_by_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_PATTERN) |-> (rsp_out_byte == 8'h00))
      else $error("byte on a non-pattern result");

   a_flags_by_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_COMPLETE) |->
      !rsp_flag_global && !rsp_flag_ignore_case && !rsp_flag_multiline)
      else $error("flags on a result that is not a completion");

   // a terminator left unconsumed always ends a literal and its run
   a_unconsumed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_consumed |->
      (rsp_kind == KIND_COMPLETE) && rsp_last_of_run)
      else $error("unconsumed byte outside a final completion");

endmodule

bind regex_literal_scanner rls_checker u_rls_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_kind             (rsp_kind),
   .rsp_out_byte         (rsp_out_byte),
   .rsp_flag_global      (rsp_flag_global),
   .rsp_flag_ignore_case (rsp_flag_ignore_case),
   .rsp_flag_multiline   (rsp_flag_multiline),
   .rsp_byte_consumed    (rsp_byte_consumed),
   .rsp_last_of_run      (rsp_last_of_run)
);

// File: dv/regex_literal_scanner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regex_literal_scanner_tb
// self-checking bench for the regex literal scanner
// ----------------------------------------------------------------------------
// a clocked driver feeds source bytes from a queue of pending beats, with
// random gaps; a clocked monitor runs a scan predictor on every accepted
// byte and compares each response beat, field by field, with the oldest
// predicted result. the receiver stalls at random. stimulus is a directed
// opening followed by random literals, broken sequences and idle noise
// ----------------------------------------------------------------------------
module regex_literal_scanner_tb;
   import rls_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RANDOM_BYTES = 280;
   localparam int DRAIN_CYCLES = 20;
   localparam int LIMIT_CYCLES = 500000;

   // one source byte as presented on the request channel
   typedef struct {
      logic [7:0] in_byte;
      logic       first;
      logic       end_of_text;
   } source_beat_t;

   // one predicted response beat
   typedef struct {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [2:0] flags;
      logic       consumed;
      logic       last;
   } scan_result_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_first = 1'b0;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_flag_global;
   logic       rsp_flag_ignore_case;
   logic       rsp_flag_multiline;
   logic       rsp_byte_consumed;
   logic       rsp_last_of_run;

   regex_literal_scanner dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_in_byte          (req_in_byte),
      .req_first            (req_first),
      .req_end_of_text      (req_end_of_text),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_flag_global      (rsp_flag_global),
      .rsp_flag_ignore_case (rsp_flag_ignore_case),
      .rsp_flag_multiline   (rsp_flag_multiline),
      .rsp_byte_consumed    (rsp_byte_consumed),
      .rsp_last_of_run      (rsp_last_of_run)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // bench state
   source_beat_t source_bytes_q[$];
   scan_result_t scan_results_q[$];
   source_beat_t cur_beat;
   logic         req_taken = 1'b0;
   int           req_gap = 0;
   int           rsp_stall = 0;
   bit           steady_run = 1'b0;
   int           cycle_count = 0;
   int           mismatches = 0;
   int           stim_count = 0;
   int           bytes_taken = 0;
   int           results_seen = 0;
   int           kind_count[4] = '{0, 0, 0, 0};

   // predictor copy of the scanner state
   logic [2:0]   scan_st = ST_IDLE;
   logic [2:0]   flags_acc = 3'b000;

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic bit breaks_line(input logic [7:0] c);
      return c inside {CH_LF, CH_CR};
   endfunction

   // bytes that close the flag list and belong to the next token
   function automatic bit ends_flags(input logic [7:0] c);
      return c inside {CH_SEMI, CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_COMMA,
                       CH_RPAREN, CH_RBRACK, CH_RBRACE, CH_DOT};
   endfunction

   function automatic scan_result_t make_result(input logic [1:0] kind,
                                                input logic [7:0] b,
                                                input logic [2:0] flags,
                                                input logic consumed);
      scan_result_t r;
      r.kind     = kind;
      r.out_byte = b;
      r.flags    = flags;
      r.consumed = consumed;
      r.last     = 1'b0;
      return r;
   endfunction

   task automatic predict_scan(input logic [7:0] c, input logic first,
                               input logic eot);
      scan_result_t run[$];
      logic [2:0]   flag_bit;
      if (first) begin
         scan_st   = ST_BODY;
         flags_acc = 3'b000;
      end
      case (scan_st)
         ST_BODY, ST_CLASS, ST_ESC_BODY, ST_ESC_CLASS: begin
            if (breaks_line(c)) begin
               // a line break anywhere in the pattern, escape included
               run.push_back(make_result(KIND_UNTERM, 8'h00, 3'b000, 1'b1));
               scan_st = ST_IDLE;
            end else if (scan_st == ST_BODY && c == CH_SLASH) begin
               scan_st   = ST_FLAGS;
               flags_acc = 3'b000;
               if (eot) begin
                  // closing slash is the last source byte: no flags
                  run.push_back(make_result(KIND_COMPLETE, 8'h00, 3'b000, 1'b1));
                  scan_st = ST_IDLE;
               end
            end else begin
               case (scan_st)
                  ST_BODY: begin
                     // lone closing bracket gets a backslash in front
                     if (c == CH_RBRACK) begin
                        run.push_back(make_result(KIND_PATTERN, CH_BSLASH, 3'b000, 1'b1));
                     end else if (c == CH_LBRACK) begin
                        scan_st = ST_CLASS;
                     end else if (c == CH_BSLASH) begin
                        scan_st = ST_ESC_BODY;
                     end
                  end
                  ST_CLASS: begin
                     if (c == CH_RBRACK) begin
                        scan_st = ST_BODY;
                     end else if (c == CH_BSLASH) begin
                        scan_st = ST_ESC_CLASS;
                     end
                  end
                  ST_ESC_BODY: begin
                     scan_st = ST_BODY;
                  end
                  default: begin
                     scan_st = ST_CLASS;
                  end
               endcase
               run.push_back(make_result(KIND_PATTERN, c, 3'b000, 1'b1));
               if (eot) begin
                  // text ran out inside the pattern
                  run.push_back(make_result(KIND_UNTERM, 8'h00, 3'b000, 1'b1));
                  scan_st = ST_IDLE;
               end
            end
         end
         ST_FLAGS: begin
            case (c)
               CH_G:    flag_bit = FLAG_G;
               CH_I:    flag_bit = FLAG_I;
               CH_M:    flag_bit = FLAG_M;
               default: flag_bit = 3'b000;
            endcase
            if (flag_bit != 3'b000) begin
               if ((flags_acc & flag_bit) != 3'b000) begin
                  // repeated flag
                  run.push_back(make_result(KIND_BAD_FLAG, 8'h00, 3'b000, 1'b1));
                  scan_st = ST_IDLE;
               end else begin
                  flags_acc = flags_acc | flag_bit;
                  if (eot) begin
                     run.push_back(make_result(KIND_COMPLETE, 8'h00, flags_acc, 1'b1));
                     scan_st = ST_IDLE;
                  end
               end
            end else if (ends_flags(c)) begin
               // terminator is left for the next token
               run.push_back(make_result(KIND_COMPLETE, 8'h00, flags_acc, 1'b0));
               scan_st = ST_IDLE;
            end else begin
               run.push_back(make_result(KIND_BAD_FLAG, 8'h00, 3'b000, 1'b1));
               scan_st = ST_IDLE;
            end
         end
         default: begin
            // idle without first: byte dropped
            scan_st = ST_IDLE;
         end
      endcase
      if (run.size() != 0) begin
         run[run.size() - 1].last = 1'b1;
      end
      foreach (run[k]) begin
         scan_results_q.push_back(run[k]);
      end
   endtask

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0d] mismatch: %s got %0d want %0d", cycle_count, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch(name, got, want);
      end
   endtask

   task automatic check_result();
      scan_result_t want;
      results_seen++;
      kind_count[rsp_kind]++;
      if (scan_results_q.size() == 0) begin
         report_mismatch("response beat with nothing predicted, kind", rsp_kind, -1);
      end else begin
         want = scan_results_q.pop_front();
         check_field("kind", rsp_kind, want.kind);
         check_field("out_byte", rsp_out_byte, want.out_byte);
         check_field("flag_global", rsp_flag_global, want.flags[0]);
         check_field("flag_ignore_case", rsp_flag_ignore_case, want.flags[1]);
         check_field("flag_multiline", rsp_flag_multiline, want.flags[2]);
         check_field("byte_consumed", rsp_byte_consumed, want.consumed);
         check_field("last_of_run", rsp_last_of_run, want.last);
      end
   endtask

   // monitor: both channels sampled at the rising edge
   always @(posedge clock) begin
      cycle_count++;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            bytes_taken++;
            predict_scan(req_in_byte, req_first, req_end_of_text);
         end
         if (rsp_valid && rsp_ready) begin
            check_result();
         end
      end
   end

   // ------------------------------------------------------------------------
   // idling
   // ------------------------------------------------------------------------
   // mostly short gaps, a few long ones, and now and then a stretch of none
   function automatic int idle_gap();
      int r;
      if ($urandom_range(0, 39) == 0) begin
         steady_run = !steady_run;
      end
      if (steady_run) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 85) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // driver: a new beat goes out at the falling edge once the old one is taken
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
            req_valid <= 1'b0;
         end else if (source_bytes_q.size() != 0) begin
            cur_beat = source_bytes_q.pop_front();
            req_in_byte     <= cur_beat.in_byte;
            req_first       <= cur_beat.first;
            req_end_of_text <= cur_beat.end_of_text;
            req_valid       <= 1'b1;
            req_gap = idle_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall = rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) begin
            rsp_stall = idle_gap();
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b, input logic first, input logic eot);
      source_beat_t s;
      s.in_byte     = b;
      s.first       = first;
      s.end_of_text = eot;
      source_bytes_q.push_back(s);
   endtask

   // plain body byte: nothing that changes the scan state
   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (c inside {CH_SLASH, CH_LBRACK, CH_RBRACK, CH_BSLASH, CH_LF, CH_CR}) begin
         c = 8'($urandom_range(0, 255));
      end
      return c;
   endfunction

   // byte inside a class; slash and open bracket are ordinary here
   function automatic logic [7:0] class_byte();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (c inside {CH_RBRACK, CH_BSLASH, CH_LF, CH_CR}) begin
         c = 8'($urandom_range(0, 255));
      end
      return c;
   endfunction

   function automatic logic [7:0] escaped_byte();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (breaks_line(c)) begin
         c = 8'($urandom_range(0, 255));
      end
      return c;
   endfunction

   function automatic logic [7:0] pick_terminator();
      case ($urandom_range(0, 9))
         0:       return CH_SEMI;
         1:       return CH_SPACE;
         2:       return CH_TAB;
         3:       return CH_CR;
         4:       return CH_LF;
         5:       return CH_COMMA;
         6:       return CH_RPAREN;
         7:       return CH_RBRACK;
         8:       return CH_RBRACE;
         default: return CH_DOT;
      endcase
   endfunction

   // byte that is neither a flag nor a terminator
   function automatic logic [7:0] bad_flag_byte();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (c inside {CH_G, CH_I, CH_M} || ends_flags(c)) begin
         c = 8'($urandom_range(0, 255));
      end
      return c;
   endfunction

   // a literal with a well-formed body and random content, ending in one of several ways
   task automatic gen_literal();
      logic [7:0] body[$];
      logic [7:0] fl[3];
      logic [7:0] t;
      int         nflags;
      int         j;
      int         ending;
      bit         eot_last;
      repeat ($urandom_range(0, 5)) begin
         case ($urandom_range(0, 5))
            0, 1: body.push_back(plain_byte());
            2: begin
               body.push_back(CH_BSLASH);
               body.push_back(escaped_byte());
            end
            3, 4: begin
               body.push_back(CH_LBRACK);
               repeat ($urandom_range(0, 3)) begin
                  if ($urandom_range(0, 2) == 0) begin
                     body.push_back(CH_BSLASH);
                     body.push_back(escaped_byte());
                  end else begin
                     body.push_back(class_byte());
                  end
               end
               body.push_back(CH_RBRACK);
            end
            default: body.push_back(CH_RBRACK);
         endcase
      end
      body.push_back(CH_SLASH);
      // flags in random order
      fl = '{CH_G, CH_I, CH_M};
      for (j = 2; j > 0; j--) begin
         int k;
         k = $urandom_range(0, j);
         t = fl[j];
         fl[j] = fl[k];
         fl[k] = t;
      end
      nflags = $urandom_range(0, 3);
      for (j = 0; j < nflags; j++) begin
         body.push_back(fl[j]);
      end
      eot_last = 1'b0;
      ending = $urandom_range(0, 9);
      if (ending < 6) begin
         body.push_back(pick_terminator());
      end else if (ending < 8) begin
         eot_last = 1'b1;
      end else if (ending == 8 && nflags > 0) begin
         body.push_back(fl[$urandom_range(0, nflags - 1)]);
      end else begin
         body.push_back(bad_flag_byte());
      end
      foreach (body[k]) begin
         push_byte(body[k], k == 0, eot_last && (k == body.size() - 1));
      end
      stim_count += body.size();
   endtask

   // short sequence of anything, with first at its head
   task automatic gen_broken();
      int         n;
      logic [7:0] c;
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(0, 7))
            0:       c = CH_SLASH;
            1:       c = CH_LBRACK;
            2:       c = CH_RBRACK;
            3:       c = CH_BSLASH;
            4:       c = breaks_line(CH_LF) && $urandom_range(0, 1) ? CH_LF : CH_CR;
            5:       c = CH_G;
            default: c = 8'($urandom_range(0, 255));
         endcase
         push_byte(c, k == 0 || $urandom_range(0, 9) == 0, $urandom_range(0, 5) == 0);
      end
      stim_count += n;
   endtask

   // bytes without first; dropped when the scan is idle
   task automatic gen_noise();
      repeat ($urandom_range(1, 3)) begin
         push_byte(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic load_directed();
      // idle without first
      push_byte("z", 1'b0, 1'b0);
      // lone bracket, class with escape, escaped slash, all flags, terminator
      push_byte("a", 1'b1, 1'b0);
      push_byte(CH_RBRACK, 1'b0, 1'b0);
      push_byte(CH_LBRACK, 1'b0, 1'b0);
      push_byte(CH_BSLASH, 1'b0, 1'b0);
      push_byte(CH_RBRACK, 1'b0, 1'b0);
      push_byte(CH_RBRACK, 1'b0, 1'b0);
      push_byte(CH_BSLASH, 1'b0, 1'b0);
      push_byte(CH_SLASH, 1'b0, 1'b0);
      push_byte(CH_SLASH, 1'b0, 1'b0);
      push_byte(CH_G, 1'b0, 1'b0);
      push_byte(CH_I, 1'b0, 1'b0);
      push_byte(CH_M, 1'b0, 1'b0);
      push_byte(CH_SEMI, 1'b0, 1'b0);
      // byte extremes, then end of text in the pattern
      push_byte(8'hff, 1'b1, 1'b0);
      push_byte(8'h00, 1'b0, 1'b1);
      // closing slash at end of text
      push_byte(CH_SLASH, 1'b1, 1'b1);
      // repeated flag
      push_byte(CH_SLASH, 1'b1, 1'b0);
      push_byte(CH_G, 1'b0, 1'b0);
      push_byte(CH_G, 1'b0, 1'b0);
      // unknown flag
      push_byte(CH_SLASH, 1'b1, 1'b0);
      push_byte("x", 1'b0, 1'b0);
      // line break right after a backslash
      push_byte(CH_BSLASH, 1'b1, 1'b0);
      push_byte(CH_CR, 1'b0, 1'b0);
      // end of text after a valid flag
      push_byte(CH_SLASH, 1'b1, 1'b0);
      push_byte(CH_M, 1'b0, 1'b1);
   endtask

   // ------------------------------------------------------------------------
   // sequence of the run
   // ------------------------------------------------------------------------
   initial begin
      int r;
      load_directed();
      while (stim_count < RANDOM_BYTES) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            gen_literal();
         end else if (r < 85) begin
            gen_broken();
         end else begin
            gen_noise();
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for the last beat to go in and every prediction to be met
      while ((source_bytes_q.size() != 0 || req_valid || scan_results_q.size() != 0) &&
             cycle_count < LIMIT_CYCLES) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results still predicted",
                  cycle_count, scan_results_q.size());
         mismatches++;
      end else if (scan_results_q.size() != 0) begin
         report_mismatch("predicted results never seen", 0, scan_results_q.size());
      end

      $display("run covered %0d source bytes and %0d response beats in %0d cycles",
               bytes_taken, results_seen, cycle_count);
      $display("beats by kind: pattern %0d, complete %0d, unterminated %0d, bad flag %0d",
               kind_count[KIND_PATTERN], kind_count[KIND_COMPLETE],
               kind_count[KIND_UNTERM], kind_count[KIND_BAD_FLAG]);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
